@@ rtl/rtmp_message_chunker_assert.svh @@
// Assertion macros for the RTMP message chunker.
// Included by the top level; needs no other file.
`ifndef RTMP_MESSAGE_CHUNKER_ASSERT_SVH
`define RTMP_MESSAGE_CHUNKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RMC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rmc_pkg.sv @@
// Shared types and constants for the RTMP message chunker.
// Used by every module of the block; depends on nothing.
package rmc_pkg;

    localparam int CHUNK_LEN_W  = 24;
    localparam int SID_W        = 17;
    localparam int TS_W         = 32;
    localparam int MAX_BYTES    = 8;
    localparam int POS_W        = 3;
    localparam int HDR_MAX      = 3;
    localparam int TS_BYTES     = 4;
    localparam int S_TDATA_W    = 64;
    localparam int M_TDATA_W    = 8;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [CHUNK_LEN_W-1:0]  CHUNK_LEN_RESET  = 24'd128;
    localparam logic [7:0]              FMT_TYPE3        = 8'hC0;
    localparam logic [7:0]              FMT_TYPE3_LONG   = 8'hC1;
    localparam logic [SID_W-1:0]        SID_TWO_BYTE     = 17'd64;
    localparam logic [SID_W-1:0]        SID_THREE_BYTE   = 17'd320;
    localparam logic [SID_W-1:0]        SID_OFFSET       = 17'd64;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        t_byte [MAX_BYTES-1:0] bytes;
        logic [POS_W-1:0]      last_idx;
        logic                  mend;
    } t_desc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

@@ rtl/rmc_front.sv @@
// Front end of the RTMP message chunker: holds the chunk size and chunk position,
// and turns each accepted payload byte into a list of output bytes. Uses rmc_pkg.
module rmc_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rmc_pkg::CHUNK_LEN_W-1:0]     i_cfg_data,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [rmc_pkg::S_TDATA_W-1:0]       i_s_tdata,
    input  logic                                i_s_tlast,
    input  logic                                i_s_tuser,
    output logic                                o_push,
    output rmc_pkg::t_desc                      o_desc,
    input  rmc_pkg::t_qstat                     i_qstat
);
    import rmc_pkg::*;

    logic [CHUNK_LEN_W-1:0]  r_chunk_len;
    logic [CHUNK_LEN_W-1:0]  r_bic;
    logic [CHUNK_LEN_W-1:0]  n_bic;
    logic [CHUNK_LEN_W-1:0]  w_limit;
    logic                    w_hdr;
    logic                    w_ext;
    t_byte                   w_payload;
    logic [SID_W-1:0]        w_sid;
    logic [SID_W-1:0]        w_sid_off;
    logic [TS_W-1:0]         w_ts;
    t_byte [HDR_MAX-1:0]     w_hbytes;
    logic [1:0]              w_hcnt;
    logic [POS_W-1:0]        w_idx;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !i_qstat.full;
    assign o_push      = i_s_tvalid && o_s_tready;

    assign w_payload = i_s_tdata[7:0];
    assign w_sid     = i_s_tdata[8 +: SID_W];
    assign w_ts      = i_s_tdata[8 + SID_W +: TS_W];
    assign w_sid_off = w_sid - SID_OFFSET;
    assign w_limit   = (r_chunk_len == '0) ? CHUNK_LEN_W'(1) : r_chunk_len;
    assign w_hdr     = r_bic >= w_limit;
    assign w_ext     = w_hdr && i_s_tuser;

    always_comb begin
        w_hbytes = {HDR_MAX{FMT_TYPE3}};
        w_hcnt   = 2'd0;
        if (w_hdr) begin
            if (w_sid >= SID_THREE_BYTE) begin
                w_hbytes[0] = FMT_TYPE3_LONG;
                w_hbytes[1] = w_sid_off[7:0];
                w_hbytes[2] = w_sid_off[15:8];
                w_hcnt      = 2'd3;
            end else if (w_sid >= SID_TWO_BYTE) begin
                w_hbytes[1] = w_sid_off[7:0];
                w_hcnt      = 2'd2;
            end else begin
                w_hbytes[0] = FMT_TYPE3 | {2'b00, w_sid[5:0]};
                w_hcnt      = 2'd1;
            end
        end
    end

    always_comb begin
        w_idx          = '0;
        o_desc.bytes   = {MAX_BYTES{w_payload}};
        for (int k = 0; k < HDR_MAX; k++) begin
            if (POS_W'(k) < POS_W'(w_hcnt)) begin
                o_desc.bytes[k] = w_hbytes[k];
            end
        end
        if (w_ext) begin
            for (int j = 0; j < TS_BYTES; j++) begin
                w_idx               = POS_W'(w_hcnt) + POS_W'(j);
                o_desc.bytes[w_idx] = w_ts[TS_W-8-8*j +: 8];
            end
        end
        o_desc.last_idx = POS_W'(w_hcnt) + (w_ext ? POS_W'(TS_BYTES) : POS_W'(0));
        o_desc.mend     = i_s_tlast;
    end

    always_comb begin
        n_bic = r_bic;
        if (o_push) begin
            if (i_s_tlast) begin
                n_bic = '0;
            end else if (w_hdr) begin
                n_bic = CHUNK_LEN_W'(1);
            end else begin
                n_bic = r_bic + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_len <= CHUNK_LEN_RESET;
            r_bic       <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_chunk_len <= i_cfg_data;
            end
            r_bic <= n_bic;
        end
    end

endmodule

@@ rtl/rmc_queue.sv @@
// Short first-in first-out queue of byte lists between front and back end.
// Uses rmc_pkg for the entry and status types.
module rmc_queue #(
    parameter int DEPTH = rmc_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rmc_pkg::t_desc  i_desc,
    input  logic            i_pop,
    output rmc_pkg::t_desc  o_head,
    output rmc_pkg::t_qstat o_stat
);
    import rmc_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_desc            r_mem [DEPTH];
    logic [IDX_W-1:0] r_wr;
    logic [IDX_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] n_wr;
    logic [IDX_W-1:0] n_rd;
    logic [CNT_W-1:0] n_count;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = r_count == CNT_W'(DEPTH);
    assign o_stat.empty = r_count == '0;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == IDX_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == IDX_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

endmodule

@@ rtl/rmc_back.sv @@
// Back end of the RTMP message chunker: walks the byte list at the queue head
// and drives the registered output stream. Uses rmc_pkg.
module rmc_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rmc_pkg::t_desc                 i_head,
    input  rmc_pkg::t_qstat                i_qstat,
    output logic                           o_pop,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [rmc_pkg::M_TDATA_W-1:0]  o_m_tdata,
    output logic                           o_m_tlast,
    output logic                           o_m_tuser
);
    import rmc_pkg::*;

    logic             r_valid;
    logic [POS_W-1:0] r_pos;
    t_byte            r_data;
    logic             r_run_last;
    logic             r_frame_end;
    logic             n_valid;
    logic [POS_W-1:0] n_pos;
    logic             w_load;
    logic             w_last;

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tlast  = r_frame_end;
    assign o_m_tuser  = r_run_last;

    assign w_load = !r_valid || i_m_tready;
    assign w_last = r_pos == i_head.last_idx;
    assign o_pop  = w_load && !i_qstat.empty && w_last;

    always_comb begin
        n_valid = r_valid;
        n_pos   = r_pos;
        if (w_load) begin
            n_valid = !i_qstat.empty;
            if (!i_qstat.empty) begin
                n_pos = w_last ? '0 : r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else begin
            r_valid <= n_valid;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && !i_qstat.empty) begin
            r_data      <= i_head.bytes[r_pos];
            r_run_last  <= w_last;
            r_frame_end <= w_last && i_head.mend;
        end
    end

endmodule

@@ rtl/rtmp_message_chunker.sv @@
// Top level of the RTMP message chunker: front end, queue and back end.
// Depends on rmc_pkg, rmc_front, rmc_queue, rmc_back and the assertion header.
//
// Channel   Direction  Transfer when             Contents
// s_axis    in         i_s_tvalid & o_s_tready   payload byte, stream id, timestamp
// m_axis    out        o_m_tvalid & i_m_tready   one byte of the chunk stream
// cfg       in         i_cfg_valid & o_cfg_ready chunk size
//
// Each input transfer yields 1, 2 to 4, or 6 to 8 output bytes; the output port moves one
// byte per cycle while i_m_tready is high. The queue of QUEUE_DEPTH entries lets the input
// keep taking one byte per cycle, until the queue is full, while header bytes drain.
// With an empty queue the first output byte passes through the queue and the output register.
// Reset is synchronous and active low; the chunk size returns to 128.
// Stalls on the output fill the queue, and o_s_tready falls when it is full.
module rtmp_message_chunker #(
    parameter int QUEUE_DEPTH = rmc_pkg::QUEUE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rmc_pkg::CHUNK_LEN_W-1:0]    i_cfg_data,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // payload_byte [7:0], stream_channel [24:8], ext_timestamp [56:25], zeros above
    input  logic [rmc_pkg::S_TDATA_W-1:0]      i_s_tdata,
    input  logic                               i_s_tlast,
    // ext_ts_enable
    input  logic                               i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // raw_byte [7:0]
    output logic [rmc_pkg::M_TDATA_W-1:0]      o_m_tdata,
    output logic                               o_m_tlast,
    // run_last
    output logic                               o_m_tuser
);
    import rmc_pkg::*;

    `include "rtmp_message_chunker_assert.svh"

    logic   w_push;
    logic   w_pop;
    t_desc  w_desc;
    t_desc  w_head;
    t_qstat w_qstat;
    logic   w_out_xfer;

    assign w_out_xfer = o_m_tvalid && i_m_tready;

    rmc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_s_tuser   (i_s_tuser),
        .o_push      (w_push),
        .o_desc      (w_desc),
        .i_qstat     (w_qstat)
    );

    rmc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_desc),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    rmc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_qstat    (w_qstat),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    `RMC_ASSERT_NOW(a_fend, i_clk, i_rst_n, o_m_tvalid && o_m_tlast, o_m_tuser, "bad frame end")
    `RMC_ASSERT_NEXT(a_run, i_clk, i_rst_n, w_out_xfer && !o_m_tuser, o_m_tvalid, "gap in run")
    `RMC_ASSERT_NOW(a_qstat, i_clk, i_rst_n, w_qstat.full, !w_qstat.empty, "full and empty")
    `RMC_ASSERT_NEXT(a_push, i_clk, i_rst_n, w_push && w_qstat.empty, !w_qstat.empty, "push lost")

endmodule

@@ tb/tb_rtmp_message_chunker.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the RTMP message chunker: drives payload bytes and
// chunk size writes, predicts the chunk stream and compares every output byte.
// Depends on rmc_pkg and rtmp_message_chunker.
module tb_rtmp_message_chunker;
    import rmc_pkg::*;

    class chunk_stream_scoreboard;
        typedef struct packed {
            logic [7:0] raw;
            logic       run_last;
            logic       frame_end;
        } t_out_byte;

        logic [CHUNK_LEN_W-1:0]  chunk_len;
        logic [CHUNK_LEN_W-1:0]  bytes_in_chunk;
        t_out_byte               expected_bytes[$];
        int                      errors;

        function new();
            chunk_len      = CHUNK_LEN_RESET;
            bytes_in_chunk = '0;
            errors         = 0;
        endfunction

        function void set_chunk_len(logic [CHUNK_LEN_W-1:0] value);
            chunk_len = value;
        endfunction

        function void push_byte(logic [7:0] raw, logic run_last, logic frame_end);
            t_out_byte item;
            item.raw       = raw;
            item.run_last  = run_last;
            item.frame_end = frame_end;
            expected_bytes.push_back(item);
        endfunction

        function void note_payload(logic [7:0] data, logic mend, logic [SID_W-1:0] sid,
                                   logic ts_en, logic [TS_W-1:0] ts);
            logic [CHUNK_LEN_W-1:0]  limit;
            logic [SID_W-1:0]        offset;
            limit  = (chunk_len == '0) ? 24'd1 : chunk_len;
            offset = sid - SID_OFFSET;
            if (bytes_in_chunk >= limit) begin
                if (sid >= SID_THREE_BYTE) begin
                    push_byte(FMT_TYPE3_LONG, 1'b0, 1'b0);
                    push_byte(offset[7:0], 1'b0, 1'b0);
                    push_byte(offset[15:8], 1'b0, 1'b0);
                end else if (sid >= SID_TWO_BYTE) begin
                    push_byte(FMT_TYPE3, 1'b0, 1'b0);
                    push_byte(offset[7:0], 1'b0, 1'b0);
                end else begin
                    push_byte(FMT_TYPE3 | {2'b00, sid[5:0]}, 1'b0, 1'b0);
                end
                if (ts_en) begin
                    push_byte(ts[31:24], 1'b0, 1'b0);
                    push_byte(ts[23:16], 1'b0, 1'b0);
                    push_byte(ts[15:8], 1'b0, 1'b0);
                    push_byte(ts[7:0], 1'b0, 1'b0);
                end
                bytes_in_chunk = '0;
            end
            push_byte(data, 1'b1, mend);
            if (mend) begin
                bytes_in_chunk = '0;
            end else begin
                bytes_in_chunk = bytes_in_chunk + 1'b1;
            end
        endfunction

        function void check_byte(logic [7:0] raw, logic run_last, logic frame_end);
            t_out_byte exp_item;
            if (expected_bytes.size() == 0) begin
                $error("unexpected output byte %0h", raw);
                errors++;
            end else begin
                exp_item = expected_bytes.pop_front();
                if (raw !== exp_item.raw) begin
                    $error("raw_byte: expected %0h, actual %0h", exp_item.raw, raw);
                    errors++;
                end
                if (run_last !== exp_item.run_last) begin
                    $error("run_last: expected %0b, actual %0b", exp_item.run_last, run_last);
                    errors++;
                end
                if (frame_end !== exp_item.frame_end) begin
                    $error("frame_end: expected %0b, actual %0b", exp_item.frame_end,
                           frame_end);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CHUNK_LEN_W-1:0]  i_cfg_data;
    logic                    i_s_tvalid;
    logic                    o_s_tready;
    logic [S_TDATA_W-1:0]    i_s_tdata;
    logic                    i_s_tlast;
    logic                    i_s_tuser;
    logic                    o_m_tvalid;
    logic                    i_m_tready;
    logic [M_TDATA_W-1:0]    o_m_tdata;
    logic                    o_m_tlast;
    logic                    o_m_tuser;

    chunk_stream_scoreboard sb;
    int                     burst_left;

    rtmp_message_chunker DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int   run_len;
        logic level;
        i_m_tready = 1'b0;
        level      = 1'b0;
        forever begin
            level = ~level;
            if (level) begin
                run_len = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 20);
            end else begin
                run_len = $urandom_range(1, 6);
            end
            repeat (run_len) begin
                @(negedge i_clk);
                i_m_tready <= level;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_byte(o_m_tdata, o_m_tuser, o_m_tlast);
        end
    end

    task automatic send_payload(input logic [7:0] data, input logic mend,
                                input logic [SID_W-1:0] sid, input logic ts_en,
                                input logic [TS_W-1:0] ts);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 24);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'b0, ts, sid, data};
        i_s_tlast  <= mend;
        i_s_tuser  <= ts_en;
        burst_left--;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_payload(data, mend, sid, ts_en, ts);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_chunk_len(input logic [CHUNK_LEN_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_chunk_len(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [SID_W-1:0] pick_stream_id();
        case ($urandom_range(0, 3))
            0:       return SID_W'($urandom_range(0, 63));
            1:       return SID_W'($urandom_range(64, 319));
            2:       return SID_W'($urandom_range(320, 65599));
            default: return SID_W'($urandom_range(65600, 131071));
        endcase
    endfunction

    task automatic run_random_phase(input int count);
        int               left;
        int               msg_len;
        logic [SID_W-1:0] sid;
        logic             ts_en;
        logic [TS_W-1:0]  ts;
        left = count;
        while (left > 0) begin
            msg_len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 12);
            sid     = pick_stream_id();
            ts_en   = 1'($urandom_range(0, 1));
            ts      = $urandom;
            for (int k = 0; k < msg_len && left > 0; k++) begin
                if ($urandom_range(0, 15) == 0) sid = pick_stream_id();
                if ($urandom_range(0, 15) == 0) ts_en = ~ts_en;
                if ($urandom_range(0, 7) == 0) ts = $urandom;
                send_payload(8'($urandom_range(0, 255)), k == msg_len - 1, sid, ts_en, ts);
                left--;
            end
        end
    endtask

    initial begin
        logic [CHUNK_LEN_W-1:0] sizes [5];
        sb          = new();
        burst_left  = 0;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tlast   = 1'b0;
        i_s_tuser   = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_payload(8'h00, 1'b0, 17'd0, 1'b0, 32'h0);
        send_payload(8'hFF, 1'b0, 17'd100, 1'b1, 32'hFFFFFFFF);
        send_payload(8'h5A, 1'b1, 17'd400, 1'b1, 32'h12345678);
        wait_idle();

        // A chunk size of zero behaves as one: each byte after a message's first gets a header.
        write_chunk_len(24'd0);
        send_payload(8'h00, 1'b0, 17'd0, 1'b0, 32'h0);
        send_payload(8'hFF, 1'b0, 17'd63, 1'b1, 32'hFFFFFFFF);
        send_payload(8'h11, 1'b0, 17'd64, 1'b0, 32'h0);
        send_payload(8'h22, 1'b0, 17'd319, 1'b1, 32'h01234567);
        send_payload(8'h33, 1'b0, 17'd320, 1'b0, 32'h0);
        send_payload(8'h44, 1'b0, 17'd65599, 1'b1, 32'h0);
        send_payload(8'h55, 1'b0, 17'd65600, 1'b0, 32'hFFFFFFFF);
        send_payload(8'h66, 1'b0, 17'd131071, 1'b1, 32'h80000001);
        send_payload(8'h77, 1'b1, 17'd1000, 1'b1, 32'hA5A55A5A);
        send_payload(8'h88, 1'b1, 17'd5, 1'b1, 32'h0);
        wait_idle();

        // Lowering the chunk size in the middle of a message forces a header at once.
        write_chunk_len(24'hFFFFFF);
        send_payload(8'h01, 1'b0, 17'd2, 1'b0, 32'h0);
        send_payload(8'h02, 1'b0, 17'd2, 1'b0, 32'h0);
        send_payload(8'h03, 1'b0, 17'd2, 1'b0, 32'h0);
        send_payload(8'h04, 1'b0, 17'd2, 1'b0, 32'h0);
        wait_idle();
        write_chunk_len(24'd2);
        send_payload(8'h05, 1'b0, 17'd2, 1'b1, 32'hDEADBEEF);
        send_payload(8'h06, 1'b1, 17'd2, 1'b1, 32'hDEADBEEF);
        wait_idle();

        sizes[0] = 24'd1;
        sizes[1] = 24'd3;
        sizes[2] = 24'd7;
        sizes[3] = 24'd2;
        sizes[4] = CHUNK_LEN_W'($urandom_range(4, 12));
        for (int p = 0; p < 5; p++) begin
            write_chunk_len(sizes[p]);
            run_random_phase(42);
            wait_idle();
        end

        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
